>>> rtl/u8u16_pkg.sv
// shared types and constants of the utf-8 to utf-16 transcoder
`default_nettype none
package u8u16_pkg;

  // width of the unit limit register and of the written-unit counter
  localparam int LIMIT_W = 13;
  // output capacity ceiling in utf-16 units
  localparam int MAX_UNITS = 4096;
  // clamp value, kept inside the limit register range
  localparam logic [LIMIT_W-1:0] LIMIT_CAP =
    (MAX_UNITS > 8191) ? LIMIT_W'(8191) : LIMIT_W'(MAX_UNITS);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  // decoupling queue between decoder and emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // lead byte thresholds and masks
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;

  // overlong floors and code space ceiling
  localparam logic [20:0] FLOOR_SEQ4 = 21'h00FFFF;
  localparam logic [20:0] FLOOR_SEQ3 = 21'h0007FF;
  localparam logic [20:0] FLOOR_SEQ2 = 21'h00007F;
  localparam logic [20:0] CP_MAX = 21'h10FFFF;
  localparam logic [20:0] SUPP_BASE = 21'h010000;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

  // sequence class: number of continuation bytes
  localparam logic [1:0] SEQ_TWO = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR = 2'd3;

  // result status codes
  typedef enum logic [1:0] {
    ST_UNIT    = 2'd0,
    ST_DONE    = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // one queued outcome of a byte: one result, or a surrogate pair
  typedef struct packed {
    logic        pair;
    logic [15:0] unit0;
    logic [15:0] unit1;
    status_t     status;
  } queue_entry_t;

endpackage
`default_nettype wire

>>> rtl/u8u16_if.sv
// channel interfaces: byte input and utf-16 result output
`default_nettype none
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first;

  modport source (output valid, in_byte, first, input ready);
  modport sink (input valid, in_byte, first, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, code_unit, status, last, input ready);
  modport sink (input valid, code_unit, status, last, output ready);
endinterface
`default_nettype wire

>>> rtl/u8u16_front.sv
// decoder front: classifies bytes, gathers sequences, queues outcomes
`default_nettype none
module u8u16_front (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               accept,
  input  wire  [7:0]                        in_byte,
  input  wire                               first,
  input  wire  [u8u16_pkg::LIMIT_W-1:0]     unit_limit,
  output logic                              push,
  output u8u16_pkg::queue_entry_t           entry
);
  import u8u16_pkg::*;

  logic [20:0]        acc_r, acc_nxt;
  logic [1:0]         pending_r, pending_nxt;
  logic [1:0]         class_r, class_nxt;
  logic [LIMIT_W-1:0] written_r, written_nxt;
  logic               discard_r, discard_nxt;

  logic [20:0]        eff_acc;
  logic [1:0]         eff_pending;
  logic [1:0]         eff_class;
  logic [LIMIT_W-1:0] eff_written;
  logic               eff_discard;
  logic [LIMIT_W-1:0] limit;
  logic [20:0]        cp;
  logic [20:0]        floor_val;
  logic [19:0]        cp_off;
  logic               want_push;

  // effective limit after the capacity clamp
  assign limit = (unit_limit > LIMIT_CAP) ? LIMIT_CAP : unit_limit;

  // a first-flagged byte sees a cleared string state
  assign eff_acc     = first ? '0 : acc_r;
  assign eff_pending = first ? '0 : pending_r;
  assign eff_class   = first ? '0 : class_r;
  assign eff_written = first ? '0 : written_r;
  assign eff_discard = first ? 1'b0 : discard_r;

  // accumulator after this continuation byte, and its checks
  assign cp = {eff_acc[14:0], in_byte[5:0]};
  assign cp_off = 20'(cp - SUPP_BASE);

  always_comb begin
    case (eff_class)
      SEQ_FOUR:  floor_val = FLOOR_SEQ4;
      SEQ_THREE: floor_val = FLOOR_SEQ3;
      default:   floor_val = FLOOR_SEQ2;
    endcase
  end

  // byte decoding
  always_comb begin
    acc_nxt      = eff_acc;
    pending_nxt  = eff_pending;
    class_nxt    = eff_class;
    written_nxt  = eff_written;
    discard_nxt  = eff_discard;
    want_push    = 1'b0;
    entry.pair   = 1'b0;
    entry.unit0  = '0;
    entry.unit1  = '0;
    entry.status = ST_UNIT;
    if (!eff_discard) begin
      if (eff_pending == 2'd0) begin
        if (eff_written >= limit) begin
          want_push    = 1'b1;
          entry.status = ST_FULL;
          discard_nxt  = 1'b1;
        end else if (!in_byte[7]) begin
          want_push   = 1'b1;
          written_nxt = eff_written + 1'b1;
          if (in_byte == 8'h00) begin
            entry.status = ST_DONE;
            discard_nxt  = 1'b1;
          end else begin
            entry.unit0 = {8'h00, in_byte};
          end
        end else if (({1'b0, eff_written} + 1'b1) >= {1'b0, limit}) begin
          want_push    = 1'b1;
          entry.status = ST_FULL;
          discard_nxt  = 1'b1;
        end else if (in_byte >= LEAD4_MIN) begin
          acc_nxt     = {18'd0, in_byte[2:0]};
          class_nxt   = SEQ_FOUR;
          pending_nxt = SEQ_FOUR;
        end else if (in_byte >= LEAD3_MIN) begin
          acc_nxt     = {17'd0, in_byte[3:0]};
          class_nxt   = SEQ_THREE;
          pending_nxt = SEQ_THREE;
        end else if (in_byte >= LEAD2_MIN) begin
          acc_nxt     = {16'd0, in_byte[4:0]};
          class_nxt   = SEQ_TWO;
          pending_nxt = SEQ_TWO;
        end else begin
          want_push    = 1'b1;
          entry.status = ST_INVALID;
          discard_nxt  = 1'b1;
        end
      end else if (!in_byte[7]) begin
        // byte with bit 7 clear where a continuation byte was expected
        want_push    = 1'b1;
        entry.status = ST_INVALID;
        discard_nxt  = 1'b1;
        pending_nxt  = 2'd0;
      end else begin
        acc_nxt     = cp;
        pending_nxt = eff_pending - 1'b1;
        if (eff_pending == 2'd1) begin
          want_push = 1'b1;
          if (cp <= floor_val || cp > CP_MAX) begin
            entry.status = ST_INVALID;
            discard_nxt  = 1'b1;
          end else if (cp > FLOOR_SEQ4) begin
            entry.pair  = 1'b1;
            entry.unit0 = HI_SURR_BASE + {6'd0, cp_off[19:10]};
            entry.unit1 = LO_SURR_BASE + {6'd0, cp_off[9:0]};
            written_nxt = eff_written + LIMIT_W'(2);
          end else begin
            entry.unit0 = cp[15:0];
            written_nxt = eff_written + 1'b1;
          end
        end
      end
    end
  end

  assign push = accept && want_push;

  // string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      pending_r <= '0;
      class_r   <= '0;
      written_r <= '0;
      discard_r <= 1'b0;
    end else if (accept) begin
      acc_r     <= acc_nxt;
      pending_r <= pending_nxt;
      class_r   <= class_nxt;
      written_r <= written_nxt;
      discard_r <= discard_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/u8u16_queue.sv
// short register queue between decoder and emitter
`default_nettype none
module u8u16_queue (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      push,
  input  u8u16_pkg::queue_entry_t  wr_entry,
  input  wire                      pop,
  output u8u16_pkg::queue_entry_t  rd_entry,
  output logic                     empty,
  output logic                     full
);
  import u8u16_pkg::*;

  queue_entry_t       slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign rd_entry = slots_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

>>> rtl/u8u16_back.sv
// emitter back: splits queued outcomes into result transactions
`default_nettype none
module u8u16_back (
  input  wire                      clk,
  input  wire                      rst_n,
  input  u8u16_pkg::queue_entry_t  head,
  input  wire                      q_empty,
  output logic                     pop,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [15:0]              out_code_unit,
  output u8u16_pkg::status_t       out_status,
  output logic                     out_last
);
  import u8u16_pkg::*;

  logic        valid_r;
  logic [15:0] unit_r;
  status_t     status_r;
  logic        last_r;
  logic        second_r;
  logic [15:0] second_unit_r;
  logic        load;

  // output register may take a new result
  assign load = !valid_r || out_ready;
  assign pop  = load && !second_r && !q_empty;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else if (load) begin
      if (second_r) begin
        valid_r  <= 1'b1;
        second_r <= 1'b0;
      end else begin
        valid_r  <= !q_empty;
        second_r <= !q_empty && head.pair;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (second_r) begin
        unit_r   <= second_unit_r;
        status_r <= ST_UNIT;
        last_r   <= 1'b1;
      end else if (!q_empty) begin
        unit_r        <= head.unit0;
        status_r      <= head.status;
        last_r        <= !head.pair;
        second_unit_r <= head.unit1;
      end
    end
  end

  assign out_valid     = valid_r;
  assign out_code_unit = unit_r;
  assign out_status    = status_r;
  assign out_last      = last_r;

endmodule
`default_nettype wire

>>> rtl/utf8_to_utf16_transcoder_unit.sv
// utf-8 to utf-16 transcoder top level
// Input channel in_chan: one utf-8 byte per transaction, with first set on
//   the opening byte of each string (this clears all string state).
// Output channel out_chan: utf-16 code units with a status (unit, string
//   done, invalid encoding, buffer full); last marks the final result that
//   a byte causes. Supplementary code points give a surrogate pair.
// Configuration: cfg_we writes cfg_wdata into the unit limit (capacity in
//   units, terminator included, clamped to 4096); write only while idle.
// Timing: an accepted byte's result passes through the queue and then the
//   output register when the output side is free. Bytes that only extend a
//   sequence or that fall in the dropped tail of a string give no result.
// Throughput: one byte per cycle while the queue is not full. The emitter
//   puts out one result per cycle while the receiver is ready, so the halves
//   of a surrogate pair go out one after the other; a four-entry queue between
//   decoder and emitter absorbs this and input ready drops only when that queue is full.
// Reset: synchronous, rst_n low clears string state, queue and output
//   register; the unit limit returns to 4096.
// Receiver stall: the held result stays on out_chan, the queue fills and
//   then in_chan.ready goes low until the receiver resumes.
`default_nettype none
module utf8_to_utf16_transcoder_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  u8u16_byte_if.sink                      in_chan,
  u8u16_unit_if.source                    out_chan,
  input  wire                             cfg_we,
  input  wire  [u8u16_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import u8u16_pkg::*;

  logic [LIMIT_W-1:0] unit_limit_r;
  logic               accept;
  logic               push;
  logic               pop;
  logic               q_empty;
  logic               q_full;
  queue_entry_t       wr_entry;
  queue_entry_t       head;
  status_t            out_status;

  // unit limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unit_limit_r <= cfg_wdata;
    end
  end

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;

  u8u16_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_chan.in_byte),
    .first      (in_chan.first),
    .unit_limit (unit_limit_r),
    .push       (push),
    .entry      (wr_entry)
  );

  u8u16_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  u8u16_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_code_unit (out_chan.code_unit),
    .out_status    (out_status),
    .out_last      (out_chan.last)
  );

  assign out_chan.status = out_status;

`ifndef NO_ASSERTIONS
  // decoder never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("queue written while full");

  // emitter never reads an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("queue read while empty");

  // end-of-string results carry no unit and close their byte
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_status != ST_UNIT) |->
      (out_chan.code_unit == 16'h0000 && out_chan.last))
    else $error("end-of-string result malformed");

  // the first half of a pair is followed by its low surrogate
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !out_chan.last) |=>
      (out_chan.valid && out_chan.last && out_status == ST_UNIT))
    else $error("surrogate pair broken");
`endif

endmodule
`default_nettype wire
